FILE: hw/rtl/lscalc_pkg.sv
// ----------------------------------------------------------------------------
// Light sensor lux calculation package
// Shared types, band codes, coefficients and the ratio power table function.
// ----------------------------------------------------------------------------
package lscalc_pkg;

   localparam int unsigned POW_TABLE_ENTRIES_DEF = 256;
   localparam int unsigned LUX_FRAC_BITS_DEF     = 8;

   localparam int unsigned DIV_STAGES  = 16;
   localparam int unsigned BACK_STAGES = 8;
   localparam int unsigned LATENCY     = 2 + DIV_STAGES + BACK_STAGES;

   localparam logic [15:0] RATIO_BAND0_MAX = 16'd34078;
   localparam logic [19:0] LUX_MAX         = 20'hFFFFF;

   localparam logic [2:0] BAND_0    = 3'd0;
   localparam logic [2:0] BAND_1    = 3'd1;
   localparam logic [2:0] BAND_2    = 3'd2;
   localparam logic [2:0] BAND_3    = 3'd3;
   localparam logic [2:0] BAND_NONE = 3'd4;

   localparam logic [11:0] COEF_B0_POS = 12'd2064;
   localparam logic [11:0] COEF_B0_NEG = 12'd3886;
   localparam logic [11:0] COEF_B1_POS = 12'd1501;
   localparam logic [11:0] COEF_B1_NEG = 12'd1907;
   localparam logic [11:0] COEF_B2_POS = 12'd1029;
   localparam logic [11:0] COEF_B2_NEG = 12'd1180;
   localparam logic [11:0] COEF_B3_POS = 12'd222;
   localparam logic [11:0] COEF_B3_NEG = 12'd170;

   typedef struct packed {
      logic [15:0] broadband_count;
      logic [15:0] infrared_count;
   } req_type;

   typedef struct packed {
      logic [19:0] lux_value;
      logic [2:0]  ratio_band;
   } rsp_type;

   typedef struct packed {
      logic [15:0] ch0;
      logic [15:0] ch1;
      logic [2:0]  band;
      logic [47:0] pos;
      logic [47:0] neg;
   } item_type;

   function automatic longint unsigned fifth_power(longint unsigned y);
      longint unsigned p;
      p = y;
      for (int k = 0; k < 4; k++) begin
         p = (p * y) >> 16;
      end
      return p;
   endfunction

   function automatic logic [15:0] pow_entry(int unsigned i, int unsigned n);
      longint unsigned n1;
      longint unsigned num;
      longint unsigned r;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned target;
      n1  = longint'(n) - 1;
      num = longint'(i) * longint'(RATIO_BAND0_MAX) + (n1 >> 1);
      lo  = 0;
      hi  = 65535;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * n1 <= num) lo = mid;
         else hi = mid - 1;
      end
      r      = lo;
      target = (r * r) >> 16;
      lo     = 0;
      hi     = 65536;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (fifth_power(mid) <= target) lo = mid;
         else hi = mid - 1;
      end
      return 16'((r * lo) >> 16);
   endfunction

endpackage

FILE: hw/rtl/lscalc_front.sv
// ----------------------------------------------------------------------------
// Lux calculation front end
// Accepts a request, picks the ratio band and forms the linear terms.
// ----------------------------------------------------------------------------
module lscalc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  lscalc_pkg::req_type req_data,
   input  logic                q_full,
   output logic                busy,
   output logic                push,
   output lscalc_pkg::item_type push_item
);

   logic                 valid_ff;
   logic                 valid_in;
   lscalc_pkg::item_type item_ff;
   lscalc_pkg::item_type item_in;
   logic                 stall;
   logic [23:0]          ch1_x100;
   logic [23:0]          ch0_x52;
   logic [23:0]          ch0_x65;
   logic [23:0]          ch0_x80;
   logic [23:0]          ch0_x130;
   logic [11:0]          cpos;
   logic [11:0]          cneg;

   assign stall = valid_ff && q_full;
   assign busy  = stall;
   assign push  = valid_ff && !q_full;
   assign push_item = item_ff;

   always_comb begin
      ch1_x100 = 24'(req_data.infrared_count) * 24'd100;
      ch0_x52  = 24'(req_data.broadband_count) * 24'd52;
      ch0_x65  = 24'(req_data.broadband_count) * 24'd65;
      ch0_x80  = 24'(req_data.broadband_count) * 24'd80;
      ch0_x130 = 24'(req_data.broadband_count) * 24'd130;
      item_in.ch0 = req_data.broadband_count;
      item_in.ch1 = req_data.infrared_count;
      cpos = '0;
      cneg = '0;
      if (req_data.broadband_count == 16'd0) begin
         item_in.band = lscalc_pkg::BAND_NONE;
      end else if (ch1_x100 <= ch0_x52) begin
         item_in.band = lscalc_pkg::BAND_0;
         cpos = lscalc_pkg::COEF_B0_POS;
      end else if (ch1_x100 <= ch0_x65) begin
         item_in.band = lscalc_pkg::BAND_1;
         cpos = lscalc_pkg::COEF_B1_POS;
         cneg = lscalc_pkg::COEF_B1_NEG;
      end else if (ch1_x100 <= ch0_x80) begin
         item_in.band = lscalc_pkg::BAND_2;
         cpos = lscalc_pkg::COEF_B2_POS;
         cneg = lscalc_pkg::COEF_B2_NEG;
      end else if (ch1_x100 <= ch0_x130) begin
         item_in.band = lscalc_pkg::BAND_3;
         cpos = lscalc_pkg::COEF_B3_POS;
         cneg = lscalc_pkg::COEF_B3_NEG;
      end else begin
         item_in.band = lscalc_pkg::BAND_NONE;
      end
      item_in.pos = (48'(req_data.broadband_count) * 48'(cpos)) << 16;
      item_in.neg = (48'(req_data.infrared_count) * 48'(cneg)) << 16;
      valid_in = stall ? valid_ff : start;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (!stall) item_ff <= item_in;
   end

endmodule

FILE: hw/rtl/lscalc_queue.sv
// ----------------------------------------------------------------------------
// Lux calculation request queue
// Two-entry queue between front and back end; drains one entry a cycle.
// ----------------------------------------------------------------------------
module lscalc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lscalc_pkg::item_type push_item,
   output logic                 full,
   output logic                 head_valid,
   output lscalc_pkg::item_type head_item
);

   lscalc_pkg::item_type mem [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_item  = mem[rd_ptr_ff];
   assign pop        = head_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) mem[wr_ptr_ff] <= push_item;
   end

endmodule

FILE: hw/rtl/lscalc_div.sv
// ----------------------------------------------------------------------------
// Lux calculation ratio divider
// Pipelined restoring divider, one quotient bit a stage: ratio = ch1*2^16/ch0.
// ----------------------------------------------------------------------------
module lscalc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  lscalc_pkg::item_type in_item,
   output logic                 out_valid,
   output lscalc_pkg::item_type out_item,
   output logic [15:0]          out_ratio
);

   localparam int unsigned S = lscalc_pkg::DIV_STAGES;

   logic                 valid_ff [S];
   lscalc_pkg::item_type item_ff  [S];
   logic [15:0]          rem_ff   [S];
   logic [15:0]          quo_ff   [S];
   logic [15:0]          rem_src  [S];
   logic [15:0]          quo_src  [S];
   lscalc_pkg::item_type item_src [S];
   logic                 valid_src [S];
   logic [16:0]          shifted  [S];
   logic [16:0]          trial    [S];

   for (genvar s = 0; s < S; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign rem_src[s]   = in_item.ch1;
         assign quo_src[s]   = '0;
         assign item_src[s]  = in_item;
         assign valid_src[s] = in_valid;
      end else begin : g_next
         assign rem_src[s]   = rem_ff[s-1];
         assign quo_src[s]   = quo_ff[s-1];
         assign item_src[s]  = item_ff[s-1];
         assign valid_src[s] = valid_ff[s-1];
      end
      assign shifted[s] = {rem_src[s], 1'b0};
      assign trial[s]   = shifted[s] - {1'b0, item_src[s].ch0};

      always_ff @(posedge clock) begin
         if (reset) valid_ff[s] <= 1'b0;
         else valid_ff[s] <= valid_src[s];
         item_ff[s] <= item_src[s];
         if (shifted[s] >= {1'b0, item_src[s].ch0}) begin
            rem_ff[s] <= trial[s][15:0];
            quo_ff[s] <= {quo_src[s][14:0], 1'b1};
         end else begin
            rem_ff[s] <= shifted[s][15:0];
            quo_ff[s] <= {quo_src[s][14:0], 1'b0};
         end
      end
   end

   assign out_valid = valid_ff[S-1];
   assign out_item  = item_ff[S-1];
   assign out_ratio = quo_ff[S-1];

endmodule

FILE: hw/rtl/lscalc_back.sv
// ----------------------------------------------------------------------------
// Lux calculation back end
// Divides, looks up ratio^1.4, forms the lux value and saturates it.
// ----------------------------------------------------------------------------
module lscalc_back #(
   parameter int unsigned POW_TABLE_ENTRIES = lscalc_pkg::POW_TABLE_ENTRIES_DEF,
   parameter int unsigned LUX_FRAC_BITS     = lscalc_pkg::LUX_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  lscalc_pkg::item_type in_item,
   output logic                 rsp_strobe,
   output lscalc_pkg::rsp_type  rsp_data
);

   localparam int unsigned IW = $clog2(POW_TABLE_ENTRIES);
   localparam int unsigned XW = 16 + IW + 1;
   localparam int unsigned K  = 40;
   localparam int unsigned MW = 25;
   localparam int unsigned PW = XW + MW;
   localparam longint unsigned RdivD = 64'd34078;
   localparam longint unsigned RecipM = (64'd1 << K) / RdivD;
   localparam logic [IW-1:0] N1 = IW'(POW_TABLE_ENTRIES - 1);
   localparam logic [XW-1:0] DivD = XW'(RdivD);
   localparam logic [XW-1:0] HalfD = XW'(RdivD / 2);
   localparam int unsigned SH = 32 - LUX_FRAC_BITS;

   logic                 d_valid;
   lscalc_pkg::item_type d_item;
   logic [15:0]          d_ratio;

   lscalc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_item   (in_item),
      .out_valid (d_valid),
      .out_item  (d_item),
      .out_ratio (d_ratio)
   );

   logic [15:0] pow_rom [POW_TABLE_ENTRIES];
   for (genvar i = 0; i < POW_TABLE_ENTRIES; i++) begin : g_rom
      assign pow_rom[i] = lscalc_pkg::pow_entry(i, POW_TABLE_ENTRIES);
   end

   logic                 v_ff   [7];
   lscalc_pkg::item_type it_ff  [7];
   logic [XW-1:0]        x_a_ff;
   logic [XW-1:0]        x_b_ff;
   logic [PW-1:0]        prod_b_ff;
   logic [IW:0]          qe_c_ff;
   logic [XW-1:0]        rem_c_ff;
   logic [IW-1:0]        idx_d_ff;
   logic [15:0]          pow_e_ff;
   logic [31:0]          m1_f_ff;
   logic [47:0]          neg_g_ff;
   logic [IW:0]          qe_in;
   logic [IW:0]          idx_full;
   logic [47:0]          diff;
   logic [47:0]          lux_full;
   logic                 out_valid_ff;
   lscalc_pkg::rsp_type  out_ff;
   lscalc_pkg::rsp_type  out_in;

   assign qe_in    = (IW+1)'(prod_b_ff >> K);
   assign idx_full = qe_c_ff + (IW+1)'(rem_c_ff >= DivD);

   always_comb begin
      diff     = (it_ff[6].pos > neg_g_ff) ? it_ff[6].pos - neg_g_ff : 48'd0;
      lux_full = diff >> SH;
      out_in.ratio_band = it_ff[6].band;
      out_in.lux_value  = (lux_full > 48'(lscalc_pkg::LUX_MAX)) ?
                          lscalc_pkg::LUX_MAX : lux_full[19:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 7; s++) v_ff[s] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v_ff[0] <= d_valid;
         for (int s = 1; s < 7; s++) v_ff[s] <= v_ff[s-1];
         out_valid_ff <= v_ff[6];
      end
      it_ff[0] <= d_item;
      for (int s = 1; s < 7; s++) it_ff[s] <= it_ff[s-1];
      x_a_ff    <= XW'(d_ratio) * XW'(N1) + HalfD;
      x_b_ff    <= x_a_ff;
      prod_b_ff <= PW'(x_a_ff) * PW'(RecipM);
      qe_c_ff   <= qe_in;
      rem_c_ff  <= x_b_ff - XW'(qe_in) * DivD;
      idx_d_ff  <= (idx_full > (IW+1)'(N1)) ? N1 : idx_full[IW-1:0];
      pow_e_ff  <= pow_rom[idx_d_ff];
      m1_f_ff   <= 32'(it_ff[4].ch0) * 32'(pow_e_ff);
      neg_g_ff  <= (it_ff[5].band == lscalc_pkg::BAND_0) ?
                   48'(m1_f_ff) * 48'(lscalc_pkg::COEF_B0_NEG) : it_ff[5].neg;
      out_ff    <= out_in;
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_data   = out_ff;

endmodule

FILE: hw/rtl/light_sensor_lux_calc_unit.sv
// ----------------------------------------------------------------------------
// Light sensor lux calculation unit
// Band selection and piecewise-linear lux formulas on two photodiode counts.
// ----------------------------------------------------------------------------
// A request is taken whenever start is high and busy is low, one per cycle;
// busy stays low in operation because the back end drains every cycle. Each
// request gives one result on rsp_data, marked by rsp_strobe for one cycle,
// after one front stage, one queue slot, the 16-stage ratio divider and
// eight back-end stages for index, table and multipliers.
// The receiver cannot stall; results leave in request order.
module light_sensor_lux_calc_unit #(
   parameter int unsigned POW_TABLE_ENTRIES = lscalc_pkg::POW_TABLE_ENTRIES_DEF,
   parameter int unsigned LUX_FRAC_BITS     = lscalc_pkg::LUX_FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lscalc_pkg::req_type req_data,
   output logic                rsp_strobe,
   output lscalc_pkg::rsp_type rsp_data
);

   logic                 q_full;
   logic                 push;
   lscalc_pkg::item_type push_item;
   logic                 head_valid;
   lscalc_pkg::item_type head_item;

   lscalc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .q_full    (q_full),
      .busy      (busy),
      .push      (push),
      .push_item (push_item)
   );

   lscalc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (q_full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   lscalc_back #(
      .POW_TABLE_ENTRIES (POW_TABLE_ENTRIES),
      .LUX_FRAC_BITS     (LUX_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (head_valid),
      .in_item    (head_item),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: hw/rtl/lscalc_checker.sv
// ----------------------------------------------------------------------------
// Lux calculation port checker
// Port-level timing and result checks, bound to the top level.
// ----------------------------------------------------------------------------
module lscalc_checker #(
   parameter int unsigned Latency = lscalc_pkg::LATENCY
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input lscalc_pkg::req_type req_data,
   input logic                rsp_strobe,
   input lscalc_pkg::rsp_type rsp_data
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_strobe_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, Latency))
      else $error("result without request");

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.ratio_band == lscalc_pkg::BAND_NONE
      |-> rsp_data.lux_value == 20'd0)
      else $error("nonzero lux outside bands");

   a_zero_broadband: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(start && !busy && req_data.broadband_count == 16'd0, Latency)
      |-> rsp_data.ratio_band == lscalc_pkg::BAND_NONE)
      else $error("zero broadband not flagged");

   a_band_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.ratio_band <= lscalc_pkg::BAND_NONE)
      else $error("band out of range");

endmodule

bind light_sensor_lux_calc_unit lscalc_checker #(
   .Latency (lscalc_pkg::LATENCY)
) u_lscalc_checker (.*);
